FILE: design/tgr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the touch gesture recognizer.
// No dependencies; imported by the top level and its checker.
package tgr_pkg;

  localparam int COORD_W = 12;
  localparam int TIME_W  = 32;
  localparam int DELTA_W = 13;
  localparam int SQ_W    = 25;           // sum of two squared deltas
  localparam int DVD_W   = SQ_W + 16;    // dividend of the zoom quotient
  localparam int ROOT_W  = 16;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = SQ_W + 1;
  localparam int CX_W    = 28;           // CORDIC vector width
  localparam int CZ_W    = 25;           // CORDIC angle width
  localparam int CNT_W   = 6;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [CZ_W-1:0] QUARTER_TURN = 25'sd2304000;
  localparam logic signed [25:0]     HEAD_BIAS    = 26'sd9216128;
  localparam logic signed [25:0]     HEAD_OFFSET  = 26'sd36000;
  localparam logic signed [25:0]     HEAD_LIMIT   = 26'sd18000;

  typedef enum logic [1:0] {
    KIND_DOWN = 2'd0,
    KIND_MOVE = 2'd1,
    KIND_UP   = 2'd2,
    KIND_TICK = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    GEST_TAP        = 3'd0,
    GEST_HOLD       = 3'd1,
    GEST_SWIPE      = 3'd2,
    GEST_DRAG_START = 3'd3,
    GEST_DRAG       = 3'd4,
    GEST_DRAG_END   = 3'd5,
    GEST_TRANSFORM  = 3'd6
  } gest_t;

  // the idle gesture state shares its code with tap
  localparam gest_t GS_NONE = GEST_TAP;

  typedef enum logic [2:0] {
    CFG_HOLD_TIMEOUT = 3'd0,
    CFG_SWIPE_TIME   = 3'd1,
    CFG_DRAG_MIN     = 3'd2,
    CFG_TAP_MAX      = 3'd3,
    CFG_SCALE_THR    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    JOB_DRAG  = 2'd0,
    JOB_SWIPE = 2'd1,
    JOB_ZOOM  = 2'd2
  } job_t;

  typedef struct packed {
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic [15:0]               zoom_ratio;
    logic signed [15:0]        heading;
    logic signed [DELTA_W-1:0] delta_y;
    logic signed [DELTA_W-1:0] delta_x;
    logic [12:0]               travel;
    logic [COORD_W-1:0]        point_y;
    logic [COORD_W-1:0]        point_x;
  } result_t;

  // arctangent of 2^-i in hundredths of a degree, Q8
  function automatic logic signed [CZ_W-1:0] atan_step(input logic [3:0] i);
    logic signed [CZ_W-1:0] a;
    case (i)
      4'd0:    a = 25'sd1152000;
      4'd1:    a = 25'sd680065;
      4'd2:    a = 25'sd359328;
      4'd3:    a = 25'sd182400;
      4'd4:    a = 25'sd91554;
      4'd5:    a = 25'sd45822;
      4'd6:    a = 25'sd22916;
      4'd7:    a = 25'sd11459;
      4'd8:    a = 25'sd5730;
      4'd9:    a = 25'sd2865;
      4'd10:   a = 25'sd1432;
      4'd11:   a = 25'sd716;
      4'd12:   a = 25'sd358;
      4'd13:   a = 25'sd179;
      4'd14:   a = 25'sd90;
      default: a = 25'sd45;
    endcase
    return a;
  endfunction

endpackage

FILE: design/touch_gesture_recognizer.sv
`timescale 1ns / 1ps
// Each accepted item is processed to completion: a one-finger move computes squares and a
// 16-step square root; a two-finger move adds the 41-step restoring divider before the root;
// a swipe up adds the CORDIC heading, and a stalled result holds the block until it is taken.
// One item at a time: in_tready is high only while idle.
// Reset (rst_n, synchronous) restores register defaults and clears all touch state.
// Top level of the touch gesture recognizer; depends on tgr_pkg.
module touch_gesture_recognizer
  import tgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // finger[3:0], pos_x[15:4], pos_y[27:16], now_ms[59:28]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // point_x[11:0], point_y[23:12], travel[36:24],
                                  // delta_x[49:37], delta_y[62:50], heading[78:63],
                                  // zoom_ratio[94:79]
  output logic [2:0]  out_tuser,  // gesture[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_DECODE = 12'b000000000010,
    ST_SQA    = 12'b000000000100,
    ST_SQB    = 12'b000000001000,
    ST_SQC    = 12'b000000010000,
    ST_SQD    = 12'b000000100000,
    ST_DIV    = 12'b000001000000,
    ST_SQRT   = 12'b000010000000,
    ST_FINISH = 12'b000100000000,
    ST_CORDIC = 12'b001000000000,
    ST_HEAD   = 12'b010000000000,
    ST_EMIT   = 12'b100000000000
  } state_t;

  function automatic logic signed [DELTA_W-1:0] diff13(input logic [COORD_W-1:0] a,
                                                       input logic [COORD_W-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // divide by 2^sh, rounding toward zero
  function automatic logic signed [CX_W-1:0] tdiv(input logic signed [CX_W-1:0] v,
                                                  input logic [3:0] sh);
    logic [CX_W-1:0]        mask;
    logic signed [CX_W-1:0] bias;
    mask = (CX_W'(1) << sh) - CX_W'(1);
    bias = v[CX_W-1] ? $signed(mask) : '0;
    return (v + bias) >>> sh;
  endfunction

  // registers
  state_t             state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  kind_t              kind_r, kind_nxt;
  logic [3:0]         finger_r, finger_nxt;
  logic [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [TIME_W-1:0]  now_r, now_nxt;

  logic [15:0]        hold_r, hold_nxt, swipe_r, swipe_nxt;
  logic [11:0]        dmin_r, dmin_nxt, tapmax_r, tapmax_nxt;
  logic [7:0]         thr_r, thr_nxt;

  logic [3:0]         fc_r, fc_nxt;
  logic               active_r, active_nxt, fdp_r, fdp_nxt, moved_r, moved_nxt;
  logic               armed_r, armed_nxt;
  gest_t              gs_r, gs_nxt, gsu_r, gsu_nxt;
  logic [TIME_W-1:0]  start_r, start_nxt;
  point_t             s0_r, s0_nxt, s1_r, s1_nxt, l0_r, l0_nxt, l1_r, l1_nxt;
  logic [12:0]        dtrav_r, dtrav_nxt;

  logic [23:0]        p_r, p_nxt;
  logic [SQ_W-1:0]    dvs_r, dvs_nxt;
  logic [DVD_W-1:0]   dvd_r, dvd_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic signed [CX_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [CZ_W-1:0] cz_r, cz_nxt;

  gest_t              res_g_r, res_g_nxt;
  result_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  gest_t              out_g_r, out_g_nxt;
  result_t            out_d_r, out_d_nxt;

  // datapath signals
  logic [TIME_W-1:0]         el;
  logic signed [DELTA_W-1:0] up_dx, up_dy, lat_dx, lat_dy, st_dx, st_dy;
  logic signed [DELTA_W-1:0] en_dx, en_dy, hd_x, hd_y, mul_in;
  logic [DELTA_W-1:0]        ax, ay, amax;
  gest_t                     tap_gs;
  logic                      tap_ok;
  logic signed [2*DELTA_W-1:0] mul_full;
  logic [23:0]               mul_p;
  logic [SQ_W-1:0]           sq_sum;
  logic [REM_W-1:0]          div_sh, div_rem;
  logic                      div_ge;
  logic [DVD_W-1:0]          quot;
  logic [18:0]               sq_sh, sq_trial, sq_rem;
  logic                      sq_ge;
  logic [3:0]                ci;
  logic signed [CX_W-1:0]    xs, ys, hx0, hy0;
  logic signed [CZ_W-1:0]    at;
  logic signed [25:0]        hz, ht;
  logic signed [15:0]        head16;
  logic [ROOT_W-1:0]         dev;

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_g_r;
  assign out_tdata  = {1'b0, out_d_r};

  // operand deltas
  assign el     = now_r - start_r;
  assign up_dx  = diff13(px_r, s0_r.x);
  assign up_dy  = diff13(py_r, s0_r.y);
  assign lat_dx = diff13(l0_r.x, s0_r.x);
  assign lat_dy = diff13(l0_r.y, s0_r.y);
  assign st_dx  = diff13(s0_r.x, s1_r.x);
  assign st_dy  = diff13(s0_r.y, s1_r.y);
  assign en_dx  = diff13(l0_r.x, l1_r.x);
  assign en_dy  = diff13(l0_r.y, l1_r.y);
  assign hd_x   = diff13(s0_r.x, l0_r.x);
  assign hd_y   = diff13(s0_r.y, l0_r.y);

  // tap test on the up position
  assign ax     = up_dx[DELTA_W-1] ? DELTA_W'(-up_dx) : DELTA_W'(up_dx);
  assign ay     = up_dy[DELTA_W-1] ? DELTA_W'(-up_dy) : DELTA_W'(up_dy);
  assign amax   = (ax > ay) ? ax : ay;
  assign tap_gs = (state_r == ST_DECODE) ? gs_r : gsu_r;
  assign tap_ok = (tap_gs != GEST_TRANSFORM) && (el <= {16'b0, hold_r}) &&
                  (amax < {1'b0, tapmax_r});

  // shared squaring unit
  always_comb begin
    mul_in = lat_dx;
    case (job_r)
      JOB_ZOOM: begin
        if (state_r == ST_SQA)      mul_in = st_dx;
        else if (state_r == ST_SQB) mul_in = st_dy;
        else if (state_r == ST_SQC) mul_in = en_dx;
        else                        mul_in = en_dy;
      end
      JOB_SWIPE: mul_in = (state_r == ST_SQA) ? up_dx : up_dy;
      default:   mul_in = (state_r == ST_SQA) ? lat_dx : lat_dy;
    endcase
  end
  assign mul_full = mul_in * mul_in;
  assign mul_p    = mul_full[23:0];
  assign sq_sum   = {1'b0, p_r} + {1'b0, mul_p};

  // restoring division step, one quotient bit a cycle
  assign div_sh  = {rem_r[REM_W-2:0], dvd_r[DVD_W-1]};
  assign div_ge  = div_sh >= {1'b0, dvs_r};
  assign div_rem = div_ge ? div_sh - {1'b0, dvs_r} : div_sh;
  assign quot    = {dvd_r[DVD_W-2:0], div_ge};

  // square root step, one root bit a cycle
  assign sq_sh    = {rem_r[16:0], rad_r[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;
  assign sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;

  // CORDIC step
  assign ci  = cnt_r[3:0];
  assign xs  = tdiv(cx_r, ci);
  assign ys  = tdiv(cy_r, ci);
  assign at  = atan_step(ci);
  assign hx0 = {{3{hd_x[DELTA_W-1]}}, hd_x, 12'b0};
  assign hy0 = {{3{hd_y[DELTA_W-1]}}, hd_y, 12'b0};

  // round the angle to hundredths and clamp
  always_comb begin
    hz = 26'(cz_r) + HEAD_BIAS;
    ht = (hz >>> 8) - HEAD_OFFSET;
    if (ht > HEAD_LIMIT)       ht = HEAD_LIMIT;
    else if (ht < -HEAD_LIMIT) ht = -HEAD_LIMIT;
    head16 = ht[15:0];
  end

  assign dev = (root_r > ROOT_W'(256)) ? root_r - ROOT_W'(256) : ROOT_W'(256) - root_r;

  // sequencer
  always_comb begin
    logic [3:0]  fc_step;
    gest_t       code;
    logic [12:0] trav;

    state_nxt = state_r;   job_nxt = job_r;     cnt_nxt = cnt_r;
    kind_nxt = kind_r;     finger_nxt = finger_r;
    px_nxt = px_r;         py_nxt = py_r;       now_nxt = now_r;
    hold_nxt = hold_r;     swipe_nxt = swipe_r; dmin_nxt = dmin_r;
    tapmax_nxt = tapmax_r; thr_nxt = thr_r;
    fc_nxt = fc_r;         active_nxt = active_r; fdp_nxt = fdp_r;
    moved_nxt = moved_r;   armed_nxt = armed_r;
    gs_nxt = gs_r;         gsu_nxt = gsu_r;     start_nxt = start_r;
    s0_nxt = s0_r;         s1_nxt = s1_r;       l0_nxt = l0_r; l1_nxt = l1_r;
    dtrav_nxt = dtrav_r;
    p_nxt = p_r;           dvs_nxt = dvs_r;     dvd_nxt = dvd_r;
    rem_nxt = rem_r;       rad_nxt = rad_r;     root_nxt = root_r;
    cx_nxt = cx_r;         cy_nxt = cy_r;       cz_nxt = cz_r;
    res_g_nxt = res_g_r;   res_nxt = res_r;
    out_valid_nxt = out_valid_r; out_g_nxt = out_g_r; out_d_nxt = out_d_r;
    fc_step = fc_r;
    code = GEST_DRAG;
    trav = root_r[12:0];

    // drop a result once taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    // register writes
    if (cfg_valid) begin
      case (cfg_index)
        CFG_HOLD_TIMEOUT: hold_nxt   = cfg_data;
        CFG_SWIPE_TIME:   swipe_nxt  = cfg_data;
        CFG_DRAG_MIN:     dmin_nxt   = cfg_data[11:0];
        CFG_TAP_MAX:      tapmax_nxt = cfg_data[11:0];
        CFG_SCALE_THR:    thr_nxt    = cfg_data[7:0];
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = kind_t'(in_tuser);
          finger_nxt = in_tdata[3:0];
          px_nxt     = in_tdata[15:4];
          py_nxt     = in_tdata[27:16];
          now_nxt    = in_tdata[59:28];
          state_nxt  = ST_DECODE;
        end
      end

      ST_DECODE: begin
        state_nxt = ST_IDLE;
        case (kind_r)
          KIND_DOWN: begin
            fc_step    = (fc_r == 4'd15) ? fc_r : fc_r + 4'd1;
            fc_nxt     = fc_step;
            fdp_nxt    = 1'b1;
            active_nxt = 1'b1;
            moved_nxt  = 1'b0;
            start_nxt  = now_r;
            if (finger_r == 4'd0) s0_nxt = '{y: py_r, x: px_r};
            if (finger_r == 4'd1) s1_nxt = '{y: py_r, x: px_r};
            gs_nxt     = GEST_HOLD;
            armed_nxt  = (fc_step == 4'd1);
          end
          KIND_MOVE: begin
            if (active_r) begin
              if (finger_r == 4'd0) begin
                l0_nxt    = '{y: py_r, x: px_r};
                moved_nxt = 1'b1;
              end
              if (finger_r == 4'd1) l1_nxt = '{y: py_r, x: px_r};
              job_nxt   = (fc_r == 4'd2) ? JOB_ZOOM : JOB_DRAG;
              state_nxt = ST_SQA;
            end
          end
          KIND_UP: begin
            fc_step = (fc_r == 4'd0) ? fc_r : fc_r - 4'd1;
            fc_nxt  = fc_step;
            if (active_r && !(gs_r != GEST_TRANSFORM && fc_step != 4'd0)) begin
              active_nxt = 1'b0;
              gsu_nxt    = gs_r;
              gs_nxt     = GS_NONE;
              if (moved_r) begin
                job_nxt   = JOB_SWIPE;
                state_nxt = ST_SQA;
              end else if (gs_r == GEST_DRAG) begin
                job_nxt   = JOB_DRAG;
                state_nxt = ST_SQA;
              end else if (tap_ok) begin
                res_g_nxt       = GEST_TAP;
                res_nxt         = '0;
                res_nxt.point_x = px_r;
                res_nxt.point_y = py_r;
                state_nxt       = ST_EMIT;
              end
            end
          end
          default: begin
            // tick: fire hold once the timeout has run out
            if (armed_r && el >= {16'b0, hold_r}) begin
              armed_nxt = 1'b0;
              if (gs_r == GEST_HOLD) begin
                res_g_nxt       = GEST_HOLD;
                res_nxt         = '0;
                res_nxt.point_x = s0_r.x;
                res_nxt.point_y = s0_r.y;
                state_nxt       = ST_EMIT;
              end
            end
          end
        endcase
      end

      ST_SQA: begin
        p_nxt     = mul_p;
        state_nxt = ST_SQB;
      end

      ST_SQB: begin
        if (job_r == JOB_ZOOM) begin
          dvs_nxt   = sq_sum;
          state_nxt = ST_SQC;
        end else begin
          rad_nxt   = RAD_W'(sq_sum);
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end

      ST_SQC: begin
        p_nxt     = mul_p;
        state_nxt = ST_SQD;
      end

      ST_SQD: begin
        if (dvs_r == '0) begin
          // coincident start fingers: saturate the zoom
          root_nxt  = '1;
          state_nxt = ST_FINISH;
        end else begin
          dvd_nxt   = {sq_sum, 16'b0};
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        rem_nxt = div_rem;
        dvd_nxt = quot;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          if (quot[DVD_W-1:RAD_W] != '0) begin
            root_nxt  = '1;
            state_nxt = ST_FINISH;
          end else begin
            rad_nxt   = quot[RAD_W-1:0];
            rem_nxt   = '0;
            root_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = ST_SQRT;
          end
        end
      end

      ST_SQRT: begin
        rem_nxt  = REM_W'(sq_rem);
        root_nxt = {root_r[ROOT_W-2:0], sq_ge};
        rad_nxt  = rad_r << 2;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(ROOT_W - 1)) state_nxt = ST_FINISH;
      end

      ST_FINISH: begin
        state_nxt = ST_IDLE;
        case (job_r)
          JOB_ZOOM: begin
            if (gs_r != GEST_DRAG && (gs_r == GEST_TRANSFORM || dev > ROOT_W'(thr_r))) begin
              gs_nxt             = GEST_TRANSFORM;
              res_g_nxt          = GEST_TRANSFORM;
              res_nxt            = '0;
              res_nxt.zoom_ratio = root_r;
              state_nxt          = ST_EMIT;
            end
          end
          JOB_DRAG: begin
            dtrav_nxt = trav;
            if (kind_r == KIND_UP) begin
              fdp_nxt   = 1'b0;
              code      = GEST_DRAG_END;
              state_nxt = ST_EMIT;
            end else if ((trav > {1'b0, dmin_r} && el > {16'b0, swipe_r}) ||
                         gs_r == GEST_DRAG) begin
              code = GEST_DRAG;
              if (fdp_r) begin
                code    = GEST_DRAG_START;
                fdp_nxt = 1'b0;
              end
              gs_nxt    = code;
              state_nxt = ST_EMIT;
            end
            res_g_nxt       = code;
            res_nxt         = '0;
            res_nxt.travel  = trav;
            res_nxt.delta_x = lat_dx;
            res_nxt.delta_y = lat_dy;
          end
          default: begin
            // swipe length test on the up position
            res_nxt         = '0;
            res_nxt.travel  = dtrav_r;
            res_nxt.delta_x = up_dx;
            res_nxt.delta_y = up_dy;
            res_g_nxt       = GEST_SWIPE;
            if (el < {16'b0, swipe_r} && root_r > ROOT_W'(dmin_r)) begin
              if (hd_x == '0 && hd_y == '0) begin
                state_nxt = ST_EMIT;
              end else begin
                cnt_nxt = '0;
                if (hd_x[DELTA_W-1]) begin
                  if (!hd_y[DELTA_W-1]) begin
                    cx_nxt = hy0;  cy_nxt = -hx0; cz_nxt = QUARTER_TURN;
                  end else begin
                    cx_nxt = -hy0; cy_nxt = hx0;  cz_nxt = -QUARTER_TURN;
                  end
                end else begin
                  cx_nxt = hx0;    cy_nxt = hy0;  cz_nxt = '0;
                end
                state_nxt = ST_CORDIC;
              end
            end else if (gsu_r == GEST_DRAG) begin
              job_nxt   = JOB_DRAG;
              state_nxt = ST_SQA;
            end else if (tap_ok) begin
              res_g_nxt       = GEST_TAP;
              res_nxt         = '0;
              res_nxt.point_x = px_r;
              res_nxt.point_y = py_r;
              state_nxt       = ST_EMIT;
            end
          end
        endcase
      end

      ST_CORDIC: begin
        if (cy_r > 0) begin
          cx_nxt = cx_r + ys;
          cy_nxt = cy_r - xs;
          cz_nxt = cz_r + at;
        end else begin
          cx_nxt = cx_r - ys;
          cy_nxt = cy_r + xs;
          cz_nxt = cz_r - at;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) state_nxt = ST_HEAD;
      end

      ST_HEAD: begin
        res_nxt.heading = head16;
        state_nxt       = ST_EMIT;
      end

      ST_EMIT: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_g_nxt     = res_g_r;
          out_d_nxt     = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      job_r       <= JOB_DRAG;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      hold_r      <= 16'd800;
      swipe_r     <= 16'd200;
      dmin_r      <= 12'd20;
      tapmax_r    <= 12'd10;
      thr_r       <= 8'd26;
      fc_r        <= '0;
      active_r    <= 1'b0;
      fdp_r       <= 1'b0;
      moved_r     <= 1'b0;
      armed_r     <= 1'b0;
      gs_r        <= GS_NONE;
      gsu_r       <= GS_NONE;
      start_r     <= '0;
      s0_r        <= '0;
      s1_r        <= '0;
      l0_r        <= '0;
      l1_r        <= '0;
      dtrav_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      job_r       <= job_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      hold_r      <= hold_nxt;
      swipe_r     <= swipe_nxt;
      dmin_r      <= dmin_nxt;
      tapmax_r    <= tapmax_nxt;
      thr_r       <= thr_nxt;
      fc_r        <= fc_nxt;
      active_r    <= active_nxt;
      fdp_r       <= fdp_nxt;
      moved_r     <= moved_nxt;
      armed_r     <= armed_nxt;
      gs_r        <= gs_nxt;
      gsu_r       <= gsu_nxt;
      start_r     <= start_nxt;
      s0_r        <= s0_nxt;
      s1_r        <= s1_nxt;
      l0_r        <= l0_nxt;
      l1_r        <= l1_nxt;
      dtrav_r     <= dtrav_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    finger_r <= finger_nxt;
    px_r     <= px_nxt;
    py_r     <= py_nxt;
    now_r    <= now_nxt;
    p_r      <= p_nxt;
    dvs_r    <= dvs_nxt;
    dvd_r    <= dvd_nxt;
    rem_r    <= rem_nxt;
    rad_r    <= rad_nxt;
    root_r   <= root_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cz_r     <= cz_nxt;
    res_g_r  <= res_g_nxt;
    res_r    <= res_nxt;
    out_g_r  <= out_g_nxt;
    out_d_r  <= out_d_nxt;
  end

endmodule

FILE: design/tgr_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the touch gesture recognizer, bound to the top level.
// Depends on tgr_pkg and touch_gesture_recognizer.
module tgr_checker
  import tgr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // the block is not ready in the cycle after it accepts an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after accepting an item");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= GEST_TRANSFORM)
    else $error("gesture code out of range");

  // tap and hold carry only a position
  a_point_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == GEST_TAP || out_tuser == GEST_HOLD)
      |-> out_tdata[95:24] == '0)
    else $error("tap or hold with motion fields set");

  a_zoom_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != GEST_TRANSFORM |-> out_tdata[94:79] == '0)
    else $error("zoom ratio set outside transform");

endmodule

bind touch_gesture_recognizer tgr_checker u_tgr_checker (.*);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for touch_gesture_recognizer: touch sequences and noise are fed in,
// a local gesture predictor sets the expected results and a monitor compares them.
// Depends on tgr_pkg and touch_gesture_recognizer.
module tb_top;
  import tgr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 120;
  localparam int MAX_REPORTS    = 10;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  localparam longint ATAN_Q8 [16] = '{
    1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459,
    5730, 2865, 1432, 716, 358, 179, 90, 45
  };

  typedef struct {
    kind_t       kind;
    logic [3:0]  finger;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] now;
  } touch_ev_t;

  typedef struct {
    gest_t   gesture;
    result_t res;
  } gesture_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  touch_ev_t    pending_events[$];
  gesture_rec_t expected_gestures[$];
  touch_ev_t    held_event;

  int send_idle_pct;
  int recv_stall_pct;
  int events_accepted;
  int gestures_seen;
  int mismatches;
  int quiet_cycles;
  logic [31:0] clock_ms;

  // predictor copy of the registers
  int unsigned hold_ms, swipe_ms, drag_min, tap_max, scale_thr;
  // predictor copy of the touch state
  int unsigned finger_cnt;
  bit          active, drag_first, moved, hold_armed;
  gest_t       gstate;
  logic [31:0] touch_t0;
  point_t      f0_start, f1_start, f0_last, f1_last;
  int unsigned travel_kept;

  touch_gesture_recognizer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned sq_sum(int dx, int dy);
    longint a, b;
    a = dx;
    b = dy;
    return longint'(a * a + b * b);
  endfunction

  function automatic logic signed [12:0] clip13(int v);
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return v[12:0];
  endfunction

  // 16-step CORDIC vectoring, hundredths of a degree
  function automatic int swipe_heading(int dy, int dx);
    longint x, y, z, t, xs, ys, d;
    if (dx == 0 && dy == 0) return 0;
    x = longint'(dx) * 4096;
    y = longint'(dy) * 4096;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 2304000;
      end else begin
        t = x; x = -y; y = t; z = -2304000;
      end
    end
    for (int i = 0; i < 16; i++) begin
      d = longint'(1) << i;
      xs = x / d;
      ys = y / d;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_Q8[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_Q8[i];
      end
    end
    t = (z + 128 + 9216000) / 256 - 36000;
    if (t > 18000) t = 18000;
    if (t < -18000) t = -18000;
    return int'(t);
  endfunction

  function automatic gesture_rec_t make_gesture(gest_t g, int px, int py, int trav,
                                                int dx, int dy, int hd, int zr);
    gesture_rec_t e;
    e.gesture = g;
    e.res.point_x = px[11:0];
    e.res.point_y = py[11:0];
    e.res.travel = trav[12:0];
    e.res.delta_x = clip13(dx);
    e.res.delta_y = clip13(dy);
    e.res.heading = hd[15:0];
    e.res.zoom_ratio = zr[15:0];
    return e;
  endfunction

  function automatic bit track_drag(logic [31:0] now, output gesture_rec_t e);
    int dx, dy;
    longint unsigned d;
    logic [31:0] el;
    gest_t code;
    dx = int'(f0_last.x) - int'(f0_start.x);
    dy = int'(f0_last.y) - int'(f0_start.y);
    d = int_root(sq_sum(dx, dy));
    el = now - touch_t0;
    travel_kept = (d > 8191) ? 8191 : int'(d);
    if (!((travel_kept > drag_min && el > swipe_ms) || gstate == GEST_DRAG)) return 0;
    code = GEST_DRAG;
    if (drag_first) begin
      code = GEST_DRAG_START;
      drag_first = 0;
    end
    if (!active) code = GEST_DRAG_END;
    gstate = code;
    e = make_gesture(code, 0, 0, travel_kept, dx, dy, 0, 0);
    return 1;
  endfunction

  function automatic bit track_zoom(output gesture_rec_t e);
    longint unsigned s2, e2, z, dev;
    s2 = sq_sum(int'(f0_start.x) - int'(f1_start.x), int'(f0_start.y) - int'(f1_start.y));
    e2 = sq_sum(int'(f0_last.x) - int'(f1_last.x), int'(f0_last.y) - int'(f1_last.y));
    z = 65535;
    if (s2 != 0) begin
      z = int_root((e2 * 65536) / s2);
      if (z > 65535) z = 65535;
    end
    dev = (z > 256) ? z - 256 : 256 - z;
    if (gstate != GEST_DRAG && (gstate == GEST_TRANSFORM || dev > scale_thr)) begin
      gstate = GEST_TRANSFORM;
      e = make_gesture(GEST_TRANSFORM, 0, 0, 0, 0, 0, 0, int'(z));
      return 1;
    end
    return 0;
  endfunction

  // advance the predicted touch state by one event
  function automatic bit recognise(touch_ev_t ev, output gesture_rec_t e);
    logic [31:0] el;
    int dx, dy, ax, ay, m, hd;
    bit hit;
    longint unsigned s;
    el = ev.now - touch_t0;
    hit = 0;
    case (ev.kind)
      KIND_DOWN: begin
        if (finger_cnt < 15) finger_cnt++;
        drag_first = 1;
        active = 1;
        moved = 0;
        touch_t0 = ev.now;
        if (ev.finger == 0) f0_start = '{y: ev.y, x: ev.x};
        if (ev.finger == 1) f1_start = '{y: ev.y, x: ev.x};
        gstate = GEST_HOLD;
        hold_armed = (finger_cnt == 1);
      end
      KIND_MOVE: begin
        if (active) begin
          if (ev.finger == 0) begin
            f0_last = '{y: ev.y, x: ev.x};
            moved = 1;
          end
          if (ev.finger == 1) f1_last = '{y: ev.y, x: ev.x};
          if (finger_cnt == 2) hit = track_zoom(e);
          else hit = track_drag(ev.now, e);
        end
      end
      KIND_UP: begin
        dx = int'(ev.x) - int'(f0_start.x);
        dy = int'(ev.y) - int'(f0_start.y);
        if (finger_cnt > 0) finger_cnt--;
        if (active && !(gstate != GEST_TRANSFORM && finger_cnt > 0)) begin
          active = 0;
          if (moved) begin
            s = int_root(sq_sum(dx, dy));
            if (el < swipe_ms && s > drag_min) begin
              hd = swipe_heading(int'(f0_start.y) - int'(f0_last.y),
                                 int'(f0_start.x) - int'(f0_last.x));
              gstate = GEST_SWIPE;
              e = make_gesture(GEST_SWIPE, 0, 0, travel_kept, dx, dy, hd, 0);
              hit = 1;
            end
          end
          if (gstate == GEST_DRAG) begin
            hit = track_drag(ev.now, e);
          end else if (gstate != GEST_TRANSFORM && !hit && el <= hold_ms) begin
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            m = ax > ay ? ax : ay;
            if (m < int'(tap_max)) begin
              e = make_gesture(GEST_TAP, ev.x, ev.y, 0, 0, 0, 0, 0);
              hit = 1;
            end
          end
          gstate = GS_NONE;
        end
      end
      default: begin
        if (hold_armed && el >= hold_ms) begin
          hold_armed = 0;
          if (gstate == GEST_HOLD) begin
            e = make_gesture(GEST_HOLD, f0_start.x, f0_start.y, 0, 0, 0, 0, 0);
            hit = 1;
          end
        end
      end
    endcase
    return hit;
  endfunction

  // drive events from the pending queue and predict on acceptance
  always @(posedge clk) begin
    logic next_valid;
    gesture_rec_t e;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tuser  <= '0;
    end else begin
      next_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        events_accepted++;
        if (recognise(held_event, e)) expected_gestures.push_back(e);
        next_valid = 1'b0;
      end
      if (!next_valid && pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        held_event = pending_events.pop_front();
        in_tdata <= {4'd0, held_event.now, held_event.y, held_event.x, held_event.finger};
        in_tuser <= held_event.kind;
        next_valid = 1'b1;
      end
      in_tvalid <= next_valid;
    end
  end

  // collect results and compare with the oldest expectation
  always @(posedge clk) begin
    gesture_rec_t e;
    result_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        gestures_seen++;
        got = out_tdata[94:0];
        if (expected_gestures.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected gesture %0d data %h", out_tuser, out_tdata);
        end else begin
          e = expected_gestures.pop_front();
          if (out_tuser !== e.gesture || got.point_x !== e.res.point_x ||
              got.point_y !== e.res.point_y || got.travel !== e.res.travel ||
              got.delta_x !== e.res.delta_x || got.delta_y !== e.res.delta_y ||
              got.heading !== e.res.heading || got.zoom_ratio !== e.res.zoom_ratio) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("mismatch exp g%0d pt %0d,%0d tr %0d d %0d,%0d hd %0d zr %0d",
                       e.gesture, e.res.point_x, e.res.point_y, e.res.travel,
                       e.res.delta_x, e.res.delta_y, e.res.heading, e.res.zoom_ratio);
              $display("         got g%0d pt %0d,%0d tr %0d d %0d,%0d hd %0d zr %0d",
                       out_tuser, got.point_x, got.point_y, got.travel,
                       got.delta_x, got.delta_y, got.heading, got.zoom_ratio);
            end
          end
        end
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d gestures outstanding", expected_gestures.size());
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_HOLD_TIMEOUT: hold_ms   = value;
      CFG_SWIPE_TIME:   swipe_ms  = value;
      CFG_DRAG_MIN:     drag_min  = value[11:0];
      CFG_TAP_MAX:      tap_max   = value[11:0];
      CFG_SCALE_THR:    scale_thr = value[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int h, int s, int dm, int tm, int st);
    write_reg(CFG_HOLD_TIMEOUT, 16'(h));
    write_reg(CFG_SWIPE_TIME, 16'(s));
    write_reg(CFG_DRAG_MIN, 16'(dm));
    write_reg(CFG_TAP_MAX, 16'(tm));
    write_reg(CFG_SCALE_THR, 16'(st));
  endtask

  task automatic push_event(kind_t k, int f, int x, int y, int unsigned dt);
    touch_ev_t ev;
    clock_ms = clock_ms + dt;
    ev.kind = k;
    ev.finger = f[3:0];
    ev.x = (x < 0) ? 12'd0 : (x > 4095) ? 12'd4095 : x[11:0];
    ev.y = (y < 0) ? 12'd0 : (y > 4095) ? 12'd4095 : y[11:0];
    ev.now = clock_ms;
    pending_events.push_back(ev);
  endtask

  function automatic int jitter(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic int unsigned step_ms();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom_range(40);
      4, 5, 6:    return $urandom_range(250);
      7, 8:       return $urandom_range(1200);
      default:    return $urandom_range(70000);
    endcase
  endfunction

  // one random touch: single finger, two fingers or noise
  task automatic random_touch();
    int x, y, x1, y1, span, n;
    x = $urandom_range(4095);
    y = $urandom_range(4095);
    span = ($urandom_range(1)) ? 12 : 400;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        push_event(KIND_DOWN, 0, x, y, step_ms());
        n = $urandom_range(5);
        for (int i = 0; i < n; i++) begin
          x += jitter(span);
          y += jitter(span);
          if ($urandom_range(4) == 0) push_event(KIND_TICK, 0, 0, 0, step_ms());
          else push_event(KIND_MOVE, 0, x, y, step_ms());
        end
        push_event(KIND_UP, 0, x + jitter(8), y + jitter(8), step_ms());
      end
      5, 6, 7: begin
        x1 = ($urandom_range(5) == 0) ? x : x + jitter(300);
        y1 = ($urandom_range(5) == 0) ? y : y + jitter(300);
        push_event(KIND_DOWN, 0, x, y, step_ms());
        push_event(KIND_DOWN, 1, x1, y1, $urandom_range(30));
        n = $urandom_range(6);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(1)) begin
            x += jitter(span); y += jitter(span);
            push_event(KIND_MOVE, 0, x, y, $urandom_range(60));
          end else begin
            x1 += jitter(span); y1 += jitter(span);
            push_event(KIND_MOVE, 1, x1, y1, $urandom_range(60));
          end
        end
        push_event(KIND_UP, 1, x1, y1, step_ms());
        push_event(KIND_UP, 0, x, y, step_ms());
      end
      default: begin
        push_event(kind_t'($urandom_range(3)), $urandom_range(15), $urandom_range(4095),
                   $urandom_range(4095), ($urandom_range(3) == 0) ? $urandom() : step_ms());
      end
    endcase
  endtask

  // wait until the block is drained and idle
  task automatic settle();
    while (pending_events.size() > 0 || in_tvalid || expected_gestures.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    events_accepted = 0;
    gestures_seen = 0;
    mismatches = 0;
    quiet_cycles = 0;
    clock_ms = 32'hFFFF_FF00;
    hold_ms = 800; swipe_ms = 200; drag_min = 20; tap_max = 10; scale_thr = 26;
    finger_cnt = 0; active = 0; drag_first = 0; moved = 0; hold_armed = 0;
    gstate = GS_NONE; touch_t0 = '0; travel_kept = 0;
    f0_start = '0; f1_start = '0; f0_last = '0; f1_last = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, timestamps crossing the wrap
    push_event(KIND_MOVE, 0, 50, 50, 1);              // move with no touch
    push_event(KIND_DOWN, 0, 0, 0, 10);               // tap at the corner
    push_event(KIND_UP, 0, 0, 0, 100);
    push_event(KIND_DOWN, 0, 4095, 4095, 10);         // fast swipe
    push_event(KIND_MOVE, 0, 3000, 4000, 50);
    push_event(KIND_UP, 0, 3000, 4000, 50);
    push_event(KIND_DOWN, 0, 2000, 2000, 10);         // slow drag across the wrap
    push_event(KIND_MOVE, 0, 2100, 2000, 300);
    push_event(KIND_MOVE, 0, 0, 4095, 50);
    push_event(KIND_UP, 0, 0, 4095, 50);
    push_event(KIND_DOWN, 0, 700, 800, 10);           // hold
    push_event(KIND_TICK, 0, 0, 0, 800);
    push_event(KIND_UP, 0, 700, 800, 10);
    push_event(KIND_DOWN, 0, 100, 100, 10);           // zero start spacing
    push_event(KIND_DOWN, 1, 100, 100, 5);
    push_event(KIND_MOVE, 1, 400, 100, 5);
    push_event(KIND_UP, 1, 400, 100, 5);
    push_event(KIND_UP, 0, 100, 100, 5);
    push_event(KIND_DOWN, 15, 4095, 0, 5);            // untracked finger
    push_event(KIND_UP, 15, 0, 4095, 5);
    push_event(KIND_UP, 0, 0, 0, 5);                  // up with no touch
    push_event(KIND_TICK, 9, 4095, 4095, 32'hFFFF_FFFF);
    settle();

    // random phases over four idling modes, most with newly written settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      case (ph)
        0: ;
        1: write_all(0, 0, 0, 0, 0);
        2: write_all(65535, 65535, 4095, 4095, 255);
        3: write_all(800, 200, 20, 10, 26);
        4: write_all(300, 500, 5, 40, 0);
        default: write_all($urandom_range(2000), $urandom_range(600), $urandom_range(60),
                           $urandom_range(30), $urandom_range(80));
      endcase
      if (ph == 3) write_reg(CFG_UNUSED, 16'hFFFF);
      while (pending_events.size() < 90) random_touch();
      settle();
    end

    $display("covered %0d touch events and %0d gestures over eight settings",
             events_accepted, gestures_seen);
    $display("idling modes: none, sender, receiver, both; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
